FILE: sv/smsp_pkg.sv
// ----------------------------------------------------------------------------
// smsp_pkg: shared types and constants of the setup message stream parser
// Result item layout, configuration bundle, result kinds and register indexes.
// ----------------------------------------------------------------------------
package smsp_pkg;

  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic [2:0] KIND_TYPE    = 3'd0;
  localparam logic [2:0] KIND_VER_MIN = 3'd1;
  localparam logic [2:0] KIND_VER_MAX = 3'd2;
  localparam logic [2:0] KIND_MTU     = 3'd3;
  localparam logic [2:0] KIND_TOKENS  = 3'd4;
  localparam logic [2:0] KIND_KEY     = 3'd5;
  localparam logic [2:0] KIND_END     = 3'd6;

  localparam logic [1:0] CFG_KEY_CODE    = 2'd0;
  localparam logic [1:0] CFG_MTU_CODE    = 2'd1;
  localparam logic [1:0] CFG_TOKENS_CODE = 2'd2;

  localparam logic [7:0] KEY_CODE_RST    = 8'd1;
  localparam logic [7:0] MTU_CODE_RST    = 8'd4;
  localparam logic [7:0] TOKENS_CODE_RST = 8'd5;

  typedef struct packed {
    logic [7:0] key_code;
    logic [7:0] mtu_code;
    logic [7:0] tokens_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [4:0]  key_index;
    logic [1:0]  status;
    logic        eom;
  } result_t;

endpackage

FILE: sv/smsp_parser.sv
// ----------------------------------------------------------------------------
// smsp_parser: input register, parse state and per-byte decode logic
// Decodes one registered byte per cycle and emits up to two result items.
// ----------------------------------------------------------------------------
module smsp_parser import smsp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_take,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] push_cnt
);

  localparam logic [3:0] PH_TYPE     = 4'd0;
  localparam logic [3:0] PH_VER_MIN  = 4'd1;
  localparam logic [3:0] PH_VER_MAX  = 4'd2;
  localparam logic [3:0] PH_OPT_CODE = 4'd3;
  localparam logic [3:0] PH_OPT_LEN  = 4'd4;
  localparam logic [3:0] PH_PAY_KEY  = 4'd5;
  localparam logic [3:0] PH_PAY_VAL  = 4'd6;
  localparam logic [3:0] PH_PAY_SKIP = 4'd7;
  localparam logic [3:0] PH_IGNORE   = 4'd8;

  localparam logic [1:0] CLS_UNKNOWN = 2'd0;
  localparam logic [1:0] CLS_KEY     = 2'd1;
  localparam logic [1:0] CLS_MTU     = 2'd2;
  localparam logic [1:0] CLS_TOKENS  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_SETUP = 2'd1;
  localparam logic [1:0] ST_VARINT    = 2'd2;
  localparam logic [1:0] ST_OPT_LEN   = 2'd3;

  localparam logic [7:0] TYPE_SETUP = 8'h7e;
  localparam logic [7:0] SHORT_MAX  = 8'h7f;
  localparam logic [7:0] LONG_MIN   = 8'hf8;
  localparam logic [63:0] KEY_LEN   = 64'd32;

  function automatic logic [3:0] type_code(input logic [7:0] b);
    logic [3:0] c;
    c = 4'd10;
    if (b >= 8'h77 && b <= 8'h7e) c = 4'(8'h7e - b);
    else if (b == 8'h73) c = 4'd8;
    else if (b == 8'h72) c = 4'd9;
    return c;
  endfunction

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_last;

  logic [3:0]  phase, phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  left, left_next;
  logic [1:0]  ocls, ocls_next;
  logic [63:0] prem, prem_next;
  logic [4:0]  kpos, kpos_next;
  logic [1:0]  err, err_next;
  logic        taken, taken_next;

  logic        r0v, r1v, vdone, vbad;
  logic [3:0]  cnt;
  logic [63:0] prem_dec;
  logic [1:0]  end_st;
  result_t     end_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= in_take;
    end
    if (in_take) begin
      item_byte <= in_byte;
      item_last <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      acc   <= '0;
      left  <= '0;
      ocls  <= CLS_UNKNOWN;
      prem  <= '0;
      kpos  <= '0;
      err   <= ST_OK;
      taken <= 1'b0;
    end else begin
      phase <= phase_next;
      acc   <= acc_next;
      left  <= left_next;
      ocls  <= ocls_next;
      prem  <= prem_next;
      kpos  <= kpos_next;
      err   <= err_next;
      taken <= taken_next;
    end
  end

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    left_next  = left;
    ocls_next  = ocls;
    prem_next  = prem;
    kpos_next  = kpos;
    err_next   = err;
    taken_next = taken;
    r0v        = 1'b0;
    r1v        = 1'b0;
    res0       = '0;
    res1       = '0;
    end_res    = '0;
    end_st     = ST_OK;
    vdone      = 1'b0;
    vbad       = 1'b0;
    cnt        = 4'(9'h100 - {1'b0, item_byte});
    prem_dec   = prem - 64'd1;
    if (item_valid) begin
      unique case (phase)
        PH_TYPE: begin
          r0v        = 1'b1;
          res0.kind  = KIND_TYPE;
          res0.value = {60'd0, type_code(item_byte)};
          if (item_byte == TYPE_SETUP) begin
            phase_next = PH_VER_MIN;
            left_next  = '0;
          end else begin
            err_next   = ST_NOT_SETUP;
            phase_next = PH_IGNORE;
          end
        end
        PH_VER_MIN, PH_VER_MAX, PH_OPT_CODE, PH_OPT_LEN: begin
          if (left == 4'd0) begin
            if (item_byte <= SHORT_MAX) begin
              acc_next = {56'd0, item_byte};
              vdone    = 1'b1;
            end else if (item_byte < LONG_MIN) begin
              vbad = 1'b1;
            end else begin
              acc_next  = '0;
              left_next = cnt;
            end
          end else begin
            acc_next  = {acc[55:0], item_byte};
            left_next = left - 4'd1;
            vdone     = (left == 4'd1);
          end
          if (vbad) begin
            err_next   = ST_VARINT;
            phase_next = PH_IGNORE;
          end else if (vdone) begin
            if (phase == PH_VER_MIN) begin
              r0v        = 1'b1;
              res0.kind  = KIND_VER_MIN;
              res0.value = acc_next;
              phase_next = PH_VER_MAX;
            end else if (phase == PH_VER_MAX) begin
              r0v        = 1'b1;
              res0.kind  = KIND_VER_MAX;
              res0.value = acc_next;
              phase_next = PH_OPT_CODE;
            end else if (phase == PH_OPT_CODE) begin
              if (acc_next == {56'd0, cfg.key_code}) ocls_next = CLS_KEY;
              else if (acc_next == {56'd0, cfg.mtu_code}) ocls_next = CLS_MTU;
              else if (acc_next == {56'd0, cfg.tokens_code}) ocls_next = CLS_TOKENS;
              else ocls_next = CLS_UNKNOWN;
              phase_next = PH_OPT_LEN;
            end else begin
              // option length complete: check the length for the option class and open its payload, if any
              prem_next  = acc_next;
              kpos_next  = '0;
              taken_next = 1'b0;
              left_next  = '0;
              acc_next   = '0;
              if (ocls == CLS_KEY) begin
                if (prem_next != KEY_LEN) begin
                  err_next   = ST_OPT_LEN;
                  phase_next = PH_IGNORE;
                end else begin
                  phase_next = PH_PAY_KEY;
                end
              end else if (ocls == CLS_UNKNOWN) begin
                phase_next = (prem_next == 64'd0) ? PH_OPT_CODE : PH_PAY_SKIP;
              end else if (prem_next == 64'd0) begin
                err_next   = ST_VARINT;
                phase_next = PH_IGNORE;
              end else begin
                phase_next = PH_PAY_VAL;
              end
            end
          end
        end
        PH_PAY_KEY: begin
          r0v            = 1'b1;
          res0.kind      = KIND_KEY;
          res0.value     = {56'd0, item_byte};
          res0.key_index = kpos;
          kpos_next      = kpos + 5'd1;
          prem_next      = prem_dec;
          if (prem_dec == 64'd0) phase_next = PH_OPT_CODE;
        end
        PH_PAY_VAL: begin
          prem_next = prem_dec;
          if (err == ST_OK && !taken) begin
            if (left == 4'd0) begin
              if (item_byte <= SHORT_MAX) begin
                acc_next   = {56'd0, item_byte};
                taken_next = 1'b1;
              end else if (item_byte < LONG_MIN || {60'd0, cnt} > prem_dec) begin
                err_next = ST_VARINT;
              end else begin
                acc_next  = '0;
                left_next = cnt;
              end
            end else begin
              acc_next  = {acc[55:0], item_byte};
              left_next = left - 4'd1;
              if (left == 4'd1) taken_next = 1'b1;
            end
          end
          if (prem_dec == 64'd0) begin
            if (err_next != ST_OK || !taken_next) begin
              err_next   = ST_VARINT;
              phase_next = PH_IGNORE;
            end else begin
              r0v        = 1'b1;
              res0.kind  = (ocls == CLS_MTU) ? KIND_MTU : KIND_TOKENS;
              res0.value = acc_next;
              phase_next = PH_OPT_CODE;
            end
          end
        end
        PH_PAY_SKIP: begin
          prem_next = prem_dec;
          if (prem_dec == 64'd0) phase_next = PH_OPT_CODE;
        end
        default: begin
        end
      endcase

      if (item_last) begin
        if (phase_next == PH_IGNORE) end_st = err_next;
        else if (phase_next == PH_OPT_CODE) end_st = (left_next != 4'd0) ? ST_VARINT : ST_OK;
        else if (phase_next == PH_PAY_KEY || phase_next == PH_PAY_VAL ||
                 phase_next == PH_PAY_SKIP) end_st = ST_OPT_LEN;
        else end_st = ST_VARINT;
        end_res.kind   = KIND_END;
        end_res.status = end_st;
        end_res.eom    = 1'b1;
        if (r0v) begin
          r1v  = 1'b1;
          res1 = end_res;
        end else begin
          r0v  = 1'b1;
          res0 = end_res;
        end
        phase_next = PH_TYPE;
        acc_next   = '0;
        left_next  = '0;
        ocls_next  = CLS_UNKNOWN;
        prem_next  = '0;
        kpos_next  = '0;
        err_next   = ST_OK;
        taken_next = 1'b0;
      end
    end
  end

  assign push_cnt = 2'(r0v) + 2'(r1v);

endmodule

FILE: sv/smsp_result_fifo.sv
// ----------------------------------------------------------------------------
// smsp_result_fifo: result queue with a two-item write side
// Takes zero, one or two result items per cycle and delivers one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module smsp_result_fifo import smsp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [1:0]    push_cnt,
  input  result_t       in0,
  input  result_t       in1,
  output logic          out_valid,
  input  logic          out_ready,
  output result_t       out_item,
  output logic [CW-1:0] count
);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  result_t       mem [DEPTH];
  logic [PW-1:0] wr, rd, wr1;
  logic          pop;

  assign wr1       = ptr_inc(wr);
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr] <= in0;
    if (push_cnt == 2'd2) mem[wr1] <= in1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push_cnt == 2'd2) wr <= ptr_inc(wr1);
      else if (push_cnt == 2'd1) wr <= wr1;
      if (pop) rd <= ptr_inc(rd);
      count <= count + CW'(push_cnt) - CW'(pop);
    end
  end

endmodule

FILE: sv/setup_message_stream_parser.sv
// ----------------------------------------------------------------------------
// setup_message_stream_parser: byte-stream decoder for setup messages
// Decodes type, versions and options of a message and reports its end status.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one message byte per item, tlast on the final byte.
//   m_axis carries result items: tuser is the kind, tlast marks the end
//   status item of a message, tdata packs value, key index and status.
//   Three option code registers are written through cfg_we/cfg_addr/cfg_data;
//   the user must write them only while the block is idle, the block does not enforce it.
// Timing:
//   A byte is registered at acceptance and decoded in the next cycle; its
//   results are written into the result queue and then leave on m_axis in
//   order. One byte per cycle is taken as long as the result queue
//   (FIFO_DEPTH items) has room for the in-flight byte's results plus two
//   more; a byte producing two results (a decoded field and the end status)
//   leaves through the single output port as two successive items.
// Reset: parser returns to waiting for a type byte, queue empties, s_axis_tready
//   is low and the option codes return to 1 (key), 4 (mtu) and 5 (tokens).
// Stall: with m_axis_tready low the queue fills and s_axis_tready drops.
// ----------------------------------------------------------------------------
module setup_message_stream_parser import smsp_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [63:0] value, [68:64] key_index, [70:69] status
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cfg_t          cfg;
  result_t       res0, res1, out_item;
  logic [1:0]    push_cnt;
  logic [CW-1:0] fifo_count;
  logic          in_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_code    <= KEY_CODE_RST;
      cfg.mtu_code    <= MTU_CODE_RST;
      cfg.tokens_code <= TOKENS_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_CODE:    cfg.key_code    <= cfg_data;
        CFG_MTU_CODE:    cfg.mtu_code    <= cfg_data;
        CFG_TOKENS_CODE: cfg.tokens_code <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !rst && (({1'b0, fifo_count} + (CW + 1)'(push_cnt))
                         <= (CW + 1)'(FIFO_DEPTH - 2));
  assign in_take = s_axis_tvalid && s_axis_tready;

  smsp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_take  (in_take),
    .in_byte  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .res0     (res0),
    .res1     (res1),
    .push_cnt (push_cnt)
  );

  smsp_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_cnt  (push_cnt),
    .in0       (res0),
    .in1       (res1),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item),
    .count     (fifo_count)
  );

  assign m_axis_tdata = {1'b0, out_item.status, out_item.key_index, out_item.value};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.eom;

  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_END)))
    else $error("tlast and end kind disagree");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (push_cnt != 2'd0))
    else $error("final byte produced no end item");

endmodule

FILE: dv/setup_message_stream_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// setup_message_stream_parser_test: self-checking bench for the setup parser
// Feeds setup and other messages byte by byte: directed corner cases first,
// then random well-formed, truncated and corrupted messages. Several option
// code settings are used, and idle patterns change on both stream sides.
// An in-bench model predicts every result item, which is checked in order.
// ----------------------------------------------------------------------------
import smsp_pkg::*;

typedef enum logic [3:0] {
  P_TYPE, P_VER_MIN, P_VER_MAX, P_OPT_CODE, P_OPT_LEN,
  P_PAY_KEY, P_PAY_VAL, P_PAY_SKIP, P_IGNORE
} parse_phase_e;

typedef enum logic [1:0] {OPT_UNKNOWN, OPT_KEY, OPT_MTU, OPT_TOKENS} option_class_e;

localparam logic [1:0] ST_OK         = 2'd0;
localparam logic [1:0] ST_NOT_SETUP  = 2'd1;
localparam logic [1:0] ST_VARINT_ERR = 2'd2;
localparam logic [1:0] ST_LEN_ERR    = 2'd3;

localparam logic [7:0] TYPE_SETUP    = 8'h7e;
localparam logic [7:0] TYPE_DATA     = 8'h77;
localparam logic [7:0] TYPE_HC_REQ   = 8'h73;
localparam logic [7:0] TYPE_HC_REPLY = 8'h72;

localparam logic [63:0] TC_HC_REQ   = 64'd8;
localparam logic [63:0] TC_HC_REPLY = 64'd9;
localparam logic [63:0] TC_UNKNOWN  = 64'd10;

localparam logic [7:0]  SHORT_MAX = 8'h7f;
localparam int          MAX_COUNT = 8;
localparam logic [63:0] KEY_LEN   = 64'd32;

class setup_parse_checker;
  logic [7:0]    key_code, mtu_code, tokens_code;
  parse_phase_e  phase;
  logic [63:0]   acc;
  logic [3:0]    bytes_left;
  option_class_e opt_class;
  logic [63:0]   pay_left;
  logic [4:0]    key_pos;
  logic [1:0]    err;
  logic          value_taken;
  result_t       pending_results[$];
  int            fail_count;

  function new();
    key_code    = KEY_CODE_RST;
    mtu_code    = MTU_CODE_RST;
    tokens_code = TOKENS_CODE_RST;
    fail_count  = 0;
    clear_message();
  endfunction

  function void set_code(logic [1:0] idx, logic [7:0] v);
    case (idx)
      CFG_KEY_CODE:    key_code = v;
      CFG_MTU_CODE:    mtu_code = v;
      CFG_TOKENS_CODE: tokens_code = v;
      default: ;
    endcase
  endfunction

  function void clear_message();
    phase       = P_TYPE;
    acc         = '0;
    bytes_left  = '0;
    opt_class   = OPT_UNKNOWN;
    pay_left    = '0;
    key_pos     = '0;
    err         = ST_OK;
    value_taken = 1'b0;
  endfunction

  function void push(logic [2:0] kind, logic [63:0] value, logic [4:0] idx,
                     logic [1:0] st, logic eom);
    result_t r;
    r.kind      = kind;
    r.value     = value;
    r.key_index = idx;
    r.status    = st;
    r.eom       = eom;
    pending_results.push_back(r);
  endfunction

  function logic [63:0] type_code(logic [7:0] b);
    if (b >= TYPE_DATA && b <= TYPE_SETUP) return {56'd0, TYPE_SETUP - b};
    if (b == TYPE_HC_REQ) return TC_HC_REQ;
    if (b == TYPE_HC_REPLY) return TC_HC_REPLY;
    return TC_UNKNOWN;
  endfunction

  function void fail_msg(logic [1:0] code);
    err   = code;
    phase = P_IGNORE;
  endfunction

  // 1: value complete, 0: more bytes needed, -1: count too large
  function int feed_varint(logic [7:0] b);
    int count;
    if (bytes_left == 0) begin
      if (b <= SHORT_MAX) begin
        acc = {56'd0, b};
        return 1;
      end
      count = 256 - b;
      if (count > MAX_COUNT) return -1;
      acc = '0;
      bytes_left = count[3:0];
      return 0;
    end
    acc = {acc[55:0], b};
    bytes_left = bytes_left - 1'b1;
    return (bytes_left == 0) ? 1 : 0;
  endfunction

  function void start_payload(logic [63:0] len);
    pay_left    = len;
    key_pos     = '0;
    value_taken = 1'b0;
    bytes_left  = '0;
    acc         = '0;
    case (opt_class)
      OPT_KEY: begin
        if (len != KEY_LEN) fail_msg(ST_LEN_ERR);
        else phase = P_PAY_KEY;
      end
      OPT_UNKNOWN: phase = (len == 0) ? P_OPT_CODE : P_PAY_SKIP;
      default: begin
        if (len == 0) fail_msg(ST_VARINT_ERR);
        else phase = P_PAY_VAL;
      end
    endcase
  endfunction

  function void pay_val_byte(logic [7:0] b);
    int count;
    pay_left = pay_left - 1'b1;
    if (err == ST_OK && !value_taken) begin
      if (bytes_left == 0) begin
        if (b <= SHORT_MAX) begin
          acc = {56'd0, b};
          value_taken = 1'b1;
        end else begin
          count = 256 - b;
          if (count > MAX_COUNT || pay_left < 64'(count)) begin
            err = ST_VARINT_ERR;
          end else begin
            acc = '0;
            bytes_left = count[3:0];
          end
        end
      end else begin
        acc = {acc[55:0], b};
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == 0) value_taken = 1'b1;
      end
    end
    if (pay_left == 0) begin
      if (err != ST_OK || !value_taken) begin
        fail_msg(ST_VARINT_ERR);
      end else begin
        push((opt_class == OPT_MTU) ? KIND_MTU : KIND_TOKENS, acc, '0, ST_OK, 1'b0);
        phase = P_OPT_CODE;
      end
    end
  endfunction

  function void note_byte(logic [7:0] b, logic last);
    int r;
    logic [1:0] st;
    case (phase)
      P_TYPE: begin
        push(KIND_TYPE, type_code(b), '0, ST_OK, 1'b0);
        if (b == TYPE_SETUP) begin
          phase = P_VER_MIN;
          bytes_left = '0;
        end else begin
          fail_msg(ST_NOT_SETUP);
        end
      end
      P_VER_MIN, P_VER_MAX, P_OPT_CODE, P_OPT_LEN: begin
        r = feed_varint(b);
        if (r < 0) begin
          fail_msg(ST_VARINT_ERR);
        end else if (r > 0) begin
          case (phase)
            P_VER_MIN: begin
              push(KIND_VER_MIN, acc, '0, ST_OK, 1'b0);
              phase = P_VER_MAX;
            end
            P_VER_MAX: begin
              push(KIND_VER_MAX, acc, '0, ST_OK, 1'b0);
              phase = P_OPT_CODE;
            end
            P_OPT_CODE: begin
              // key beats mtu, mtu beats tokens on equal codes
              if (acc == {56'd0, key_code}) opt_class = OPT_KEY;
              else if (acc == {56'd0, mtu_code}) opt_class = OPT_MTU;
              else if (acc == {56'd0, tokens_code}) opt_class = OPT_TOKENS;
              else opt_class = OPT_UNKNOWN;
              phase = P_OPT_LEN;
            end
            default: start_payload(acc);
          endcase
        end
      end
      P_PAY_KEY: begin
        push(KIND_KEY, {56'd0, b}, key_pos, ST_OK, 1'b0);
        key_pos  = key_pos + 1'b1;
        pay_left = pay_left - 1'b1;
        if (pay_left == 0) phase = P_OPT_CODE;
      end
      P_PAY_VAL: pay_val_byte(b);
      P_PAY_SKIP: begin
        pay_left = pay_left - 1'b1;
        if (pay_left == 0) phase = P_OPT_CODE;
      end
      default: ;
    endcase
    if (last) begin
      case (phase)
        P_IGNORE:   st = err;
        P_OPT_CODE: st = (bytes_left != 0) ? ST_VARINT_ERR : ST_OK;
        P_PAY_KEY, P_PAY_VAL, P_PAY_SKIP: st = ST_LEN_ERR;
        default:    st = ST_VARINT_ERR;
      endcase
      push(KIND_END, '0, '0, st, 1'b1);
      clear_message();
    end
  endfunction

  function void check_result(logic [71:0] data, logic [2:0] kind, logic eom);
    result_t want;
    if (pending_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result kind %0d value %h", $time, kind, data[63:0]);
      return;
    end
    want = pending_results.pop_front();
    if (kind !== want.kind || data[63:0] !== want.value || data[68:64] !== want.key_index
        || data[70:69] !== want.status || data[71] !== 1'b0 || eom !== want.eom) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: mismatch exp kind %0d value %h idx %0d st %0d last %0b / got kind %0d value %h idx %0d st %0d last %0b pad %0b",
                 $time, want.kind, want.value, want.key_index, want.status, want.eom,
                 kind, data[63:0], data[68:64], data[70:69], eom, data[71]);
    end
  endfunction
endclass

module setup_message_stream_parser_test;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_LEN   = 10;
  localparam int PHASE_BYTES  = 290;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = CFG_KEY_CODE;
  logic [7:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;        // [63:0] value, [68:64] key_index, [70:69] status
  logic [2:0]  m_axis_tuser;        // [2:0] kind
  logic        m_axis_tlast;

  setup_parse_checker sb;
  logic [7:0] msg_bytes[$];
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int cycle_count = 0;

  setup_message_stream_parser DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL setup_message_stream_parser");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int nb;
    v = {$urandom(), $urandom()};
    if ($urandom_range(0, 99) < 40) return v & {56'd0, SHORT_MAX};
    nb = $urandom_range(1, 8);
    return v >> (8 * (8 - nb));
  endfunction

  function automatic int bytes_needed(logic [63:0] v);
    int n;
    n = 1;
    while (n < 8 && (v >> (8 * n)) != 0) n++;
    return n;
  endfunction

  // nb == 0: single-byte form, else a count header and nb big-endian bytes
  function automatic void add_varint(logic [63:0] v, int nb);
    logic [8:0] hdr;
    if (nb == 0) begin
      msg_bytes.push_back(v[7:0]);
    end else begin
      hdr = 9'(256 - nb);
      msg_bytes.push_back(hdr[7:0]);
      for (int i = nb - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
    end
  endfunction

  function automatic void add_value(logic [63:0] v);
    if (v <= SHORT_MAX && $urandom_range(0, 99) < 60) add_varint(v, 0);
    else add_varint(v, $urandom_range(bytes_needed(v), 8));
  endfunction

  function automatic void add_option();
    int sel, r, nb, extra, k, len;
    logic [63:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      add_value({56'd0, sb.key_code});
      len = ($urandom_range(0, 99) < 85) ? 32 : $urandom_range(0, 40);
      add_value(64'(len));
      if (len != 32) len = $urandom_range(0, len);
      repeat (len) msg_bytes.push_back(rand_byte());
    end else if (sel < 70) begin
      add_value({56'd0, (sel < 45) ? sb.mtu_code : sb.tokens_code});
      r = $urandom_range(0, 99);
      if (r < 8) begin
        add_value(64'd0);
      end else if (r < 18) begin
        // count beyond the payload or beyond eight bytes
        k = $urandom_range(1, 8);
        len = $urandom_range(1, k);
        add_value(64'(len));
        if ($urandom_range(0, 1)) msg_bytes.push_back(8'(256 - k));
        else msg_bytes.push_back(8'($urandom_range(128, 247)));
        repeat (len - 1) msg_bytes.push_back(rand_byte());
      end else begin
        v = rand_value();
        nb = (v <= SHORT_MAX && $urandom_range(0, 1)) ? 0 : $urandom_range(bytes_needed(v), 8);
        extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        add_value(64'(nb + 1 + extra));
        add_varint(v, nb);
        repeat (extra) msg_bytes.push_back(rand_byte());
      end
    end else begin
      if ($urandom_range(0, 1)) add_value({56'd0, rand_byte()});
      else add_value(rand_value());
      len = $urandom_range(0, 6);
      add_value(64'(len));
      repeat (len) msg_bytes.push_back(rand_byte());
    end
  endfunction

  function automatic void build_random_message();
    int pick, n;
    msg_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      n = $urandom_range(1, 6);
      repeat (n) msg_bytes.push_back(rand_byte());
    end else if (pick < 18) begin
      case ($urandom_range(0, 2))
        0: msg_bytes.push_back(8'(TYPE_DATA + $urandom_range(0, 6)));
        1: msg_bytes.push_back($urandom_range(0, 1) ? TYPE_HC_REQ : TYPE_HC_REPLY);
        default: msg_bytes.push_back(rand_byte());
      endcase
      n = $urandom_range(0, 3);
      repeat (n) msg_bytes.push_back(rand_byte());
    end else begin
      msg_bytes.push_back(TYPE_SETUP);
      add_value(rand_value());
      add_value(rand_value());
      n = $urandom_range(0, 3);
      repeat (n) add_option();
      if (msg_bytes.size() > 1 && $urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > n) msg_bytes.delete(msg_bytes.size() - 1);
      end
      if (msg_bytes.size() > 1 && $urandom_range(0, 99) < 6)
        msg_bytes[$urandom_range(1, msg_bytes.size() - 1)] = rand_byte();
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_byte(b, last);
  endtask

  task automatic send_message(inout int count);
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    count += msg_bytes.size();
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
  endtask

  task automatic write_codes(input logic [7:0] k, input logic [7:0] m, input logic [7:0] t);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_KEY_CODE;
    cfg_data <= k;
    sb.set_code(CFG_KEY_CODE, k);
    @(posedge clk);
    cfg_addr <= CFG_MTU_CODE;
    cfg_data <= m;
    sb.set_code(CFG_MTU_CODE, m);
    @(posedge clk);
    cfg_addr <= CFG_TOKENS_CODE;
    cfg_data <= t;
    sb.set_code(CFG_TOKENS_CODE, t);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed(inout int count);
    msg_bytes = '{TYPE_SETUP};
    send_message(count);
    msg_bytes = '{TYPE_HC_REPLY, 8'h00};
    send_message(count);
    msg_bytes = '{8'h00};
    send_message(count);
    // extreme version values, clean end after the max version
    msg_bytes = '{TYPE_SETUP};
    add_varint(64'd0, 0);
    add_varint(64'hffff_ffff_ffff_ffff, 8);
    send_message(count);
    // count of nine in the max version
    msg_bytes = '{TYPE_SETUP, SHORT_MAX};
    msg_bytes.push_back(8'hf7);
    repeat (9) msg_bytes.push_back(8'h00);
    send_message(count);
    // empty mtu payload
    msg_bytes = '{TYPE_SETUP, 8'd1, 8'd2, sb.mtu_code, 8'd0};
    send_message(count);
    // tokens varint longer than its payload
    msg_bytes = '{TYPE_SETUP, 8'd1, 8'd2, sb.tokens_code, 8'd2};
    add_varint(64'd0, 2);
    send_message(count);
  endtask

  initial begin
    int count;
    logic [7:0] k, m, t;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin k = KEY_CODE_RST; m = MTU_CODE_RST; t = TOKENS_CODE_RST; end
        1: begin k = 8'd0;   m = 8'd255; t = 8'd128; end
        2: begin k = 8'd7;   m = 8'd7;   t = 8'd7;   end
        3: begin k = 8'd255; m = 8'd0;   t = 8'd127; end
        4: begin k = rand_byte(); m = rand_byte(); t = rand_byte(); end
        default: begin
          k = 8'($urandom_range(0, 3));
          m = 8'($urandom_range(0, 3));
          t = 8'($urandom_range(0, 3));
        end
      endcase
      write_codes(k, m, t);
      if (ph < 2) begin
        src_idle_pct = 18;
        sink_idle_pct = 68;
      end else if (ph < 4) begin
        src_idle_pct = 68;
        sink_idle_pct = 18;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      count = 0;
      if (ph == 0) run_directed(count);
      while (count < PHASE_BYTES) begin
        build_random_message();
        send_message(count);
      end
      drain_results();
    end
    if (sb.fail_count == 0 && sb.pending_results.size() == 0)
      $display("PASS setup_message_stream_parser");
    else
      $display("FAIL setup_message_stream_parser");
    $finish;
  end
endmodule
